>>> rtl/vnt_pkg.sv
// Package for the value noise texture pixel unit: octave constants, widths,
// register codes and the fixed-point linear blend. No dependencies.
`default_nettype none
package vnt_pkg;

    localparam int OCTAVES_DEF    = 4;
    localparam int COORD_BITS_DEF = 10;
    localparam int OCT_MAX        = 4;

    // Output stream: intensity in tdata, clamp flag in tuser.
    localparam int INTENSITY_W = 17;
    localparam int M_DATA_W    = ((INTENSITY_W + 7) / 8) * 8;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam logic REG_NOISE_SEED = 1'b0;

    localparam int LAT_W   = 32;  // lattice value, signed Q30
    localparam int SMOOTH_W = 36; // smoothed corner, signed Q34
    localparam int SUM_W   = 42;  // octave sum plus offset, signed Q37

    localparam logic [31:0] HASH_ADD_C = 32'd1376312589;

    function automatic logic [16:0] freq_q16(input int oct);
        logic [16:0] f;
        case (oct)
            0: f = 17'd13107;
            1: f = 17'd26214;
            2: f = 17'd52428;
            3: f = 17'd104856;
            default: f = 17'd13107;
        endcase
        return f;
    endfunction

    function automatic logic [31:0] hash_mul(input int oct);
        logic [31:0] m;
        case (oct)
            0: m = 32'd15731;
            1: m = 32'd16661;
            2: m = 32'd16333;
            3: m = 32'd15541;
            default: m = 32'd15731;
        endcase
        return m;
    endfunction

    function automatic logic [31:0] hash_add(input int oct);
        logic [31:0] a;
        case (oct)
            0: a = 32'd789221;
            1: a = 32'd789389;
            2: a = 32'd790057;
            3: a = 32'd788897;
            default: a = 32'd789221;
        endcase
        return a;
    endfunction

    // a*(1-t) + b*t with t in Q0.16, rounded half up, floor division.
    function automatic logic signed [SMOOTH_W-1:0] blend(
        input logic signed [SMOOTH_W-1:0] a,
        input logic signed [SMOOTH_W-1:0] b,
        input logic [15:0] t
    );
        logic [16:0] w;
        logic signed [SMOOTH_W+18:0] v;
        w = 17'd65536 - {1'b0, t};
        v = a * $signed({1'b0, w}) + b * $signed({2'b00, t});
        v = v + $signed((SMOOTH_W+19)'(32768));
        return SMOOTH_W'(v >>> 16);
    endfunction

endpackage
`default_nettype wire

>>> rtl/vnt_hash.sv
// Four-stage pipelined integer lattice hash giving a signed Q30 lattice value.
// Depends on vnt_pkg.
`default_nettype none
module vnt_hash (
    input  wire logic                 aclk,
    input  wire logic                 en,
    input  wire logic [31:0]          x,
    input  wire logic [31:0]          y,
    input  wire logic [31:0]          seed,
    input  wire logic [31:0]          mul_a,
    input  wire logic [31:0]          add_b,
    output logic signed [vnt_pkg::LAT_W-1:0] n
);
    import vnt_pkg::*;

    logic [31:0] h0;
    logic [31:0] h_reg, h1_reg, h2_reg, hh_reg, inner_reg;
    logic [31:0] r;
    logic signed [LAT_W-1:0] n_reg;

    assign h0 = x + y * 32'd57;
    assign r  = h2_reg * inner_reg + HASH_ADD_C;

    always_ff @(posedge aclk) begin
        if (en) begin
            h_reg     <= (h0 << 13) ^ h0;
            hh_reg    <= h_reg * h_reg;
            h1_reg    <= h_reg;
            inner_reg <= hh_reg * mul_a + add_b + seed;
            h2_reg    <= h1_reg;
            n_reg     <= $signed(32'h4000_0000) - $signed({1'b0, r[30:0]});
        end
    end

    assign n = n_reg;
endmodule
`default_nettype wire

>>> rtl/value_noise_texture_pixel_unit.sv
// Top level of the four-octave 2D value noise pixel unit: stream ports, APB
// seed register and the full pipeline. Depends on vnt_pkg and vnt_hash.
//
//  Channel   Direction  Transfer content
//  s_        in         tdata: pixel_x, pixel_y
//  m_        out        tdata: intensity; tuser: was_clamped
//  APB       in/out     noise_seed at byte address 0
//
// One pixel enters per cycle while the pipeline is not frozen by the sink.
// The stages are input capture, lattice scaling, four lattice hash stages,
// 3x3 smoothing, blend along x, blend along y, and octave sum with clamping.
// Reset clears all valid bits and the seed; payload registers are not reset.
// When the output register holds a result the sink does not take, the whole
// pipeline freezes and s_tready drops, so nothing is lost or repeated.
`default_nettype none
module value_noise_texture_pixel_unit #(
    parameter int OCTAVES    = vnt_pkg::OCTAVES_DEF,
    parameter int COORD_BITS = vnt_pkg::COORD_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // s_tdata fields from bit 0: pixel_x, pixel_y, zero padding
    input  wire logic [((2*COORD_BITS+7)/8)*8-1:0] s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // m_tdata fields from bit 0: intensity (17 bits), zero padding
    output logic [vnt_pkg::M_DATA_W-1:0]        m_tdata,
    // m_tuser fields from bit 0: was_clamped
    output logic                                m_tuser,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [vnt_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import vnt_pkg::*;

    localparam int SX_W   = COORD_BITS + 17;
    localparam int HASH_D = 4;
    localparam int NSTAGE = 9;   // valid bits before the output register

    // Configuration register.
    logic [31:0] seed_reg;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NOISE_SEED) ? seed_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= 32'd0;
        end else if (psel && penable && pwrite && paddr[2] == REG_NOISE_SEED) begin
            seed_reg <= pwdata;
        end
    end

    // The whole pipeline advances unless the output register is stuck.
    logic en;
    logic m_valid_reg;
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    logic [NSTAGE-1:0] vld_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[NSTAGE-2:0], s_tvalid};
            m_valid_reg <= vld_reg[NSTAGE-1];
        end
    end

    // Input capture.
    logic [COORD_BITS-1:0] px_reg, py_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg <= s_tdata[COORD_BITS-1:0];
            py_reg <= s_tdata[2*COORD_BITS-1:COORD_BITS];
        end
    end

    // Lattice scaling: integer cell and Q0.16 fraction per octave.
    logic [31:0] xi_reg [OCTAVES];
    logic [31:0] yi_reg [OCTAVES];
    logic [15:0] tx_reg [HASH_D+3][OCTAVES];
    logic [15:0] ty_reg [HASH_D+3][OCTAVES];

    for (genvar o = 0; o < OCTAVES; o++) begin : g_scale
        logic [SX_W-1:0] sx, sy;
        assign sx = SX_W'(px_reg) * SX_W'(freq_q16(o));
        assign sy = SX_W'(py_reg) * SX_W'(freq_q16(o));
        always_ff @(posedge aclk) begin
            if (en) begin
                xi_reg[o]    <= 32'(sx[SX_W-1:16]);
                yi_reg[o]    <= 32'(sy[SX_W-1:16]);
                tx_reg[0][o] <= sx[15:0];
                ty_reg[0][o] <= sy[15:0];
            end
        end
        // Fractions follow the hash and smoothing stages.
        for (genvar d = 1; d < HASH_D + 3; d++) begin : g_dly
            always_ff @(posedge aclk) begin
                if (en) begin
                    tx_reg[d][o] <= tx_reg[d-1][o];
                    ty_reg[d][o] <= ty_reg[d-1][o];
                end
            end
        end
    end

    // Sixteen lattice hashes per octave around the cell.
    logic signed [LAT_W-1:0] g [OCTAVES][4][4];
    for (genvar o = 0; o < OCTAVES; o++) begin : g_oct
        for (genvar j = 0; j < 4; j++) begin : g_row
            for (genvar i = 0; i < 4; i++) begin : g_col
                vnt_hash u_hash (
                    .aclk  (aclk),
                    .en    (en),
                    .x     (xi_reg[o] + 32'(i) - 32'd1),
                    .y     (yi_reg[o] + 32'(j) - 32'd1),
                    .seed  (seed_reg),
                    .mul_a (hash_mul(o)),
                    .add_b (hash_add(o)),
                    .n     (g[o][j][i])
                );
            end
        end
    end

    // 3x3 smoothing at each corner, weights 1, 2 and 4 over sixteen.
    logic signed [SMOOTH_W-1:0] c_reg [OCTAVES][2][2];
    for (genvar o = 0; o < OCTAVES; o++) begin : g_smooth
        for (genvar j = 0; j < 2; j++) begin : g_sr
            for (genvar i = 0; i < 2; i++) begin : g_sc
                logic signed [SMOOTH_W-1:0] co, si, ce;
                assign co = SMOOTH_W'(g[o][j][i]) + SMOOTH_W'(g[o][j][i+2])
                          + SMOOTH_W'(g[o][j+2][i]) + SMOOTH_W'(g[o][j+2][i+2]);
                assign si = SMOOTH_W'(g[o][j+1][i]) + SMOOTH_W'(g[o][j+1][i+2])
                          + SMOOTH_W'(g[o][j][i+1]) + SMOOTH_W'(g[o][j+2][i+1]);
                assign ce = SMOOTH_W'(g[o][j+1][i+1]);
                always_ff @(posedge aclk) begin
                    if (en) begin
                        c_reg[o][j][i] <= co + (si <<< 1) + (ce <<< 2);
                    end
                end
            end
        end
    end

    // Bilinear blend, x first and then y.
    logic signed [SMOOTH_W-1:0] bx0_reg [OCTAVES];
    logic signed [SMOOTH_W-1:0] bx1_reg [OCTAVES];
    logic signed [SMOOTH_W-1:0] oct_reg [OCTAVES];
    for (genvar o = 0; o < OCTAVES; o++) begin : g_blend
        always_ff @(posedge aclk) begin
            if (en) begin
                bx0_reg[o] <= blend(c_reg[o][0][0], c_reg[o][0][1], tx_reg[HASH_D+1][o]);
                bx1_reg[o] <= blend(c_reg[o][1][0], c_reg[o][1][1], tx_reg[HASH_D+1][o]);
                oct_reg[o] <= blend(bx0_reg[o], bx1_reg[o], ty_reg[HASH_D+2][o]);
            end
        end
    end

    // Octave sum with amplitudes 1 to 1/8, offset by one and clamped.
    logic signed [SUM_W-1:0] total;
    logic [SUM_W-1:0]        rnd;
    always_comb begin
        total = $signed(SUM_W'(64'sd1 <<< 37));
        for (int o = 0; o < OCTAVES; o++) begin
            total = total + (SUM_W'(oct_reg[o]) <<< (3 - o));
        end
        rnd = $unsigned(total) + SUM_W'(64'd1 << 21);
    end

    logic [INTENSITY_W-1:0] inten_reg;
    logic                   clamp_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            if (total < 0) begin
                inten_reg <= '0;
                clamp_reg <= 1'b1;
            end else if (total > $signed(SUM_W'(64'sd1 <<< 38))) begin
                inten_reg <= INTENSITY_W'(65536);
                clamp_reg <= 1'b1;
            end else begin
                inten_reg <= rnd[22 +: INTENSITY_W];
                clamp_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'(inten_reg);
    assign m_tuser  = clamp_reg;
endmodule
`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for value_noise_texture_pixel_unit: drives pixel
// transfers, programs the seed over APB and checks every result against an
// in-file predictor of the four-octave value noise. Depends on vnt_pkg.
module tb;
    import vnt_pkg::*;

    localparam int S_W        = 24;
    localparam int WATCHDOG   = 20000;
    localparam int N_RANDOM   = 1620;
    localparam int FREQ [4]   = '{13107, 26214, 52428, 104856};
    localparam int HMUL [4]   = '{15731, 16661, 16333, 15541};
    localparam int HADD [4]   = '{789221, 789389, 790057, 788897};

    typedef struct packed {
        logic [16:0] intensity;
        logic        clamped;
    } pixel_result_t;

    // One directed row: coordinates, and optionally a result known up front.
    typedef struct {
        logic [9:0] px;
        logic [9:0] py;
        bit         known;
        pixel_result_t res;
    } pixel_row_t;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [S_W-1:0]  s_tdata = '0;
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic            m_tuser;
    logic            psel = 1'b0;
    logic            penable = 1'b0;
    logic            pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]     pwdata = '0;
    logic [31:0]     prdata;
    logic            pready;

    always #2 aclk = ~aclk;

    value_noise_texture_pixel_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predictor state: the seed register as the testbench believes it.
    logic [31:0]    seed_model = '0;
    pixel_result_t  expected_pixels[$];
    int             mismatches = 0;
    bit             sink_stall_on = 1'b1;
    bit             src_stall_on = 1'b1;
    bit             hold_off_req = 1'b0;
    int             sink_gap = 0;
    int             idle_cycles = 0;
    bit             timed_out = 1'b0;

    // Lattice hash with 32-bit wraparound, returned as signed Q30.
    function automatic longint lattice_q30(logic [31:0] x, logic [31:0] y, int oct);
        logic [31:0] h, inner, r;
        h = x + y * 32'd57;
        h = (h << 13) ^ h;
        inner = (h * h) * HMUL[oct] + HADD[oct] + seed_model;
        r = (h * inner + HASH_ADD_C) & 32'h7fffffff;
        return (longint'(1) << 30) - longint'(r);
    endfunction

    // Rounded half up; >>> on longint is an arithmetic floor shift.
    function automatic longint lerp_q34(longint a, longint b, longint t);
        return (a * (65536 - t) + b * t + 32768) >>> 16;
    endfunction

    function automatic longint octave_q34(logic [9:0] px, logic [9:0] py, int oct);
        longint sx, sy, tx, ty, co, si;
        longint g [4][4];
        longint c [2][2];
        logic [31:0] xi, yi;
        sx = longint'(px) * FREQ[oct];
        sy = longint'(py) * FREQ[oct];
        xi = sx[47:16];
        yi = sy[47:16];
        tx = sx & 16'hffff;
        ty = sy & 16'hffff;
        // A coordinate of -1 at the lattice edge wraps to all ones.
        for (int j = 0; j < 4; j++)
            for (int i = 0; i < 4; i++)
                g[j][i] = lattice_q30(xi + i - 1, yi + j - 1, oct);
        for (int j = 0; j < 2; j++)
            for (int i = 0; i < 2; i++) begin
                co = g[j][i] + g[j][i+2] + g[j+2][i] + g[j+2][i+2];
                si = g[j+1][i] + g[j+1][i+2] + g[j][i+1] + g[j+2][i+1];
                c[j][i] = co + 2 * si + 4 * g[j+1][i+1];
            end
        return lerp_q34(lerp_q34(c[0][0], c[0][1], tx), lerp_q34(c[1][0], c[1][1], tx), ty);
    endfunction

    function automatic pixel_result_t predict_pixel(logic [9:0] px, logic [9:0] py);
        pixel_result_t res;
        longint total, s;
        total = 0;
        for (int oct = 0; oct < 4; oct++)
            total += octave_q34(px, py, oct) <<< (3 - oct);
        s = (longint'(1) << 37) + total;
        if (s < 0) begin
            res = '{17'd0, 1'b1};
        end else if (s > (longint'(1) << 38)) begin
            res = '{17'd65536, 1'b1};
        end else begin
            res.intensity = 17'((s + (longint'(1) << 21)) >>> 22);
            res.clamped = 1'b0;
        end
        return res;
    endfunction

    // APB write with setup and access phases; called only when the pipeline is empty.
    task automatic apb_write_seed(logic [31:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= PADDR_W'(REG_NOISE_SEED) << 2; pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        seed_model = value;
    endtask

    // Offers one pixel and returns at its transfer, with random source gaps.
    // Valid stays high so that the next pixel can follow without a gap.
    task automatic send_pixel(logic [9:0] px, logic [9:0] py, bit known, pixel_result_t res);
        int gap;
        if (src_stall_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        expected_pixels.push_back(known ? res : predict_pixel(px, py));
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, py, px};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Waits for every pending result, then for more than the pipeline depth.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0 && !timed_out) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    // Sink side: random stall bursts, plus one long hold-off.
    always @(posedge aclk) begin
        if (hold_off_req) begin
            m_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            m_tready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end else if (sink_stall_on && $urandom_range(0, 7) == 0) begin
            m_tready <= 1'b0;
            sink_gap <= $urandom_range(0, 2);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Result checker: every accepted transfer is compared with the oldest entry.
    always @(posedge aclk) begin
        pixel_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result intensity=%0d clamp=%0b",
                             m_tdata[16:0], m_tuser);
            end else begin
                want = expected_pixels.pop_front();
                if (m_tdata[16:0] !== want.intensity || m_tuser !== want.clamped) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0b, got %0d/%0b",
                                 want.intensity, want.clamped, m_tdata[16:0], m_tuser);
                end
            end
        end
    end

    // Watchdog: counts cycles with no transfer on either stream.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > WATCHDOG) begin
            timed_out = 1'b1;
            $display("CHECKS FAILED");
            $finish;
        end
    end

    pixel_row_t directed_rows[$];
    logic [31:0] seed_list [5] = '{32'h0, 32'hffffffff, 32'h1, 32'h80000000, 32'h0};

    initial begin
        pixel_result_t none;
        none = '0;
        // Origin and the far corners; the origin hashes lattice -1 wrapped.
        directed_rows.push_back('{10'd0, 10'd0, 0, none});
        directed_rows.push_back('{10'd1023, 10'd0, 0, none});
        directed_rows.push_back('{10'd0, 10'd1023, 0, none});
        directed_rows.push_back('{10'd1023, 10'd1023, 0, none});
        directed_rows.push_back('{10'd5, 10'd5, 0, none});
        directed_rows.push_back('{10'd1, 10'd1, 0, none});
        directed_rows.push_back('{10'd512, 10'd511, 0, none});
        directed_rows.push_back('{10'h2aa, 10'h155, 0, none});
        directed_rows.push_back('{10'h155, 10'h2aa, 0, none});
        directed_rows.push_back('{10'd4, 10'd9, 0, none});

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[k])
            send_pixel(directed_rows[k].px, directed_rows[k].py,
                       directed_rows[k].known, directed_rows[k].res);
        drain_results();

        // Several seeds, extremes included; each phase starts from an idle pipeline.
        for (int phase = 0; phase < 5; phase++) begin
            apb_write_seed(phase == 2 ? $urandom() : seed_list[phase]);
            if (phase == 1) begin
                hold_off_req = 1'b1;
                fork
                    begin
                        repeat (60) @(posedge aclk);
                        hold_off_req = 1'b0;
                    end
                    for (int k = 0; k < 40; k++)
                        send_pixel(10'($urandom), 10'($urandom), 0, none);
                join
            end
            if (phase == 4) begin
                sink_stall_on = 1'b0;
                src_stall_on = 1'b0;
            end
            for (int k = 0; k < N_RANDOM / 5; k++) begin
                if ($urandom_range(0, 7) == 0)
                    send_pixel($urandom_range(0, 1) ? 10'd0 : 10'd1023,
                               $urandom_range(0, 1) ? 10'd0 : 10'd1023, 0, none);
                else
                    send_pixel(10'($urandom), 10'($urandom), 0, none);
            end
            drain_results();
        end

        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
